// ----- hw/rtl/tcb_pkg.sv -----
// ----------------------------------------------------------------------------
// tcb_pkg
// Shared types and constants of the text console character buffer: payload
// structs of both channels, character codes, result kinds, register indexes.
// ----------------------------------------------------------------------------
package tcb_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    localparam logic [CFG_IDX_W-1:0] REG_ROWS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_QUIET = 2'd2;

    localparam logic [6:0] ROWS_RESET  = 7'd28;
    localparam logic [6:0] COLS_RESET  = 7'd33;
    localparam logic       QUIET_RESET = 1'b1;

    localparam logic FUNC_PUT  = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] CH_EMPTY = 8'h00;

    localparam int TAB_WIDTH = 4;

    localparam logic [1:0] KIND_WRITE  = 2'd0;
    localparam logic [1:0] KIND_SCROLL = 2'd1;
    localparam logic [1:0] KIND_READ   = 2'd2;

    typedef struct packed {
        logic       func;
        logic [7:0] char_code;
        logic       force_req;
        logic [5:0] read_row;
        logic [6:0] read_col;
    } tcb_in_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [5:0] row;
        logic [6:0] col;
        logic [7:0] code;
        logic       last;
    } tcb_out_t;

endpackage

// ----- hw/rtl/text_console_buffer_top.sv -----
// ----------------------------------------------------------------------------
// text_console_buffer_top
// Character store of a text console: puts bytes at a cursor with line feed,
// carriage return, tab and wrap handling, scrolls by half a screen when the
// rows run out, and returns stored cells on read requests.
// ----------------------------------------------------------------------------
//  channel   ports                        direction  payload
//  input     s_valid s_ready s_data       in         tcb_pkg::tcb_in_t
//  result    m_valid m_ready m_data       out        tcb_pkg::tcb_out_t
//  config    cfg_valid cfg_ready          in         cfg_index, cfg_data
//
//  read and plain put: one result each; tab: one result per space written
//  scroll: sweeps rows * cols in use (limited to the store), one store cell
//  per cycle through the single write port; a wrapping byte follows the scroll
//  after reset all MAX_ROWS * MAX_COLS store cells are cleared, s_ready low
//  a stalled result holds the block in its emitting state; input is taken
//  again once the block is back in idle, with the last result still waiting
// ----------------------------------------------------------------------------
module text_console_buffer_top #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 96
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  tcb_pkg::tcb_in_t               s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output tcb_pkg::tcb_out_t              m_data,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [tcb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tcb_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int RW    = $clog2(MAX_ROWS);
    localparam int RW1   = $clog2(MAX_ROWS + 1);
    localparam int CW    = $clog2(MAX_COLS + 1);
    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = $clog2(DEPTH);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_TAB,
        ST_PUT,
        ST_SWEEP,
        ST_EVENT
    } state_t;

    function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r,
                                                input logic [CW-1:0] c);
        return AW'(32'(r) * MAX_COLS + 32'(c));
    endfunction

    logic [7:0] store_mem [DEPTH];

    state_t            state_reg, state_next;
    logic [RW-1:0]     cur_row_reg, cur_row_next;
    logic [CW-1:0]     cur_col_reg, cur_col_next;
    logic [6:0]        rows_cfg_reg, rows_cfg_next;
    logic [6:0]        cols_cfg_reg, cols_cfg_next;
    logic              quiet_reg, quiet_next;
    tcb_pkg::tcb_in_t  req_reg, req_next;
    logic              rd_ok_reg, rd_ok_next;
    logic [CW:0]       tab_stop_reg, tab_stop_next;
    logic              pend_put_reg, pend_put_next;
    logic [RW-1:0]     sc_row_reg, sc_row_next;
    logic [CW-1:0]     sc_col_reg, sc_col_next;
    logic [AW-1:0]     clr_addr_reg, clr_addr_next;
    logic              m_valid_reg, m_valid_next;
    tcb_pkg::tcb_out_t m_data_reg, m_data_next;
    logic              wr_valid_reg, wr_valid_next;
    logic [AW-1:0]     wr_addr_reg, wr_addr_next;
    logic              wr_from_rd_reg, wr_from_rd_next;
    logic [7:0]        wr_data_reg, wr_data_next;

    logic [7:0]        mem_q_reg;
    logic              fwd_hit_reg;
    logic [7:0]        fwd_data_reg;

    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic [7:0]        rd_data;
    logic [7:0]        wdata;

    logic [RW1-1:0]    eff_rows;
    logic [CW-1:0]     eff_cols;
    logic [RW1-1:0]    keep;
    logic [RW1-1:0]    top_rows;
    logic [RW-1:0]     scroll_row;
    logic [RW1-1:0]    row_inc;
    logic [CW:0]       col_inc;
    logic              out_free;
    logic              tab_last;
    logic              rd_in_range;
    logic              sweep_ok;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    assign eff_rows   = (32'(rows_cfg_reg) > MAX_ROWS) ? RW1'(MAX_ROWS) : RW1'(rows_cfg_reg);
    assign eff_cols   = (32'(cols_cfg_reg) > MAX_COLS) ? CW'(MAX_COLS) : CW'(cols_cfg_reg);
    assign keep       = eff_rows >> 1;
    assign top_rows   = eff_rows - keep;
    assign scroll_row = (32'(top_rows) >= MAX_ROWS) ? RW'(MAX_ROWS - 1) : RW'(top_rows);
    assign row_inc    = RW1'(cur_row_reg) + RW1'(1);
    assign col_inc    = (CW+1)'(cur_col_reg) + (CW+1)'(1);
    assign out_free   = !m_valid_reg || m_ready;
    assign tab_last   = (col_inc == tab_stop_reg) || (col_inc >= (CW+1)'(eff_cols));
    assign sweep_ok   = (eff_rows != '0) && (eff_cols != '0);
    assign rd_in_range = (32'(s_data.read_row) < MAX_ROWS) && (32'(s_data.read_col) < MAX_COLS);

    assign rd_data = fwd_hit_reg ? fwd_data_reg : mem_q_reg;
    assign wdata   = wr_from_rd_reg ? rd_data : wr_data_reg;

    // store: one write port, one registered read port with write forwarding
    always_ff @(posedge aclk) begin
        if (wr_valid_reg) begin
            store_mem[wr_addr_reg] <= wdata;
        end
        if (rd_en) begin
            mem_q_reg    <= store_mem[rd_addr];
            fwd_hit_reg  <= wr_valid_reg && (wr_addr_reg == rd_addr);
            fwd_data_reg <= wdata;
        end
    end

    always_comb begin
        state_next      = state_reg;
        cur_row_next    = cur_row_reg;
        cur_col_next    = cur_col_reg;
        rows_cfg_next   = rows_cfg_reg;
        cols_cfg_next   = cols_cfg_reg;
        quiet_next      = quiet_reg;
        req_next        = req_reg;
        rd_ok_next      = rd_ok_reg;
        tab_stop_next   = tab_stop_reg;
        pend_put_next   = pend_put_reg;
        sc_row_next     = sc_row_reg;
        sc_col_next     = sc_col_reg;
        clr_addr_next   = clr_addr_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;
        wr_valid_next   = 1'b0;
        wr_addr_next    = wr_addr_reg;
        wr_from_rd_next = 1'b0;
        wr_data_next    = wr_data_reg;
        rd_en           = 1'b0;
        rd_addr         = '0;

        if (cfg_valid) begin
            unique case (cfg_index)
                tcb_pkg::REG_ROWS:  rows_cfg_next = cfg_data;
                tcb_pkg::REG_COLS:  cols_cfg_next = cfg_data;
                tcb_pkg::REG_QUIET: quiet_next    = cfg_data[0];
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_CLEAR: begin
                wr_valid_next = 1'b1;
                wr_addr_next  = clr_addr_reg;
                wr_data_next  = tcb_pkg::CH_EMPTY;
                if (clr_addr_reg == AW'(DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end else begin
                    clr_addr_next = clr_addr_reg + AW'(1);
                end
            end

            ST_IDLE: begin
                if (s_valid) begin
                    req_next = s_data;
                    if (s_data.func == tcb_pkg::FUNC_READ) begin
                        rd_ok_next = rd_in_range;
                        rd_en      = rd_in_range;
                        rd_addr    = cell_addr(RW'(s_data.read_row), CW'(s_data.read_col));
                        state_next = ST_READ;
                    end else if (!quiet_reg || s_data.force_req) begin
                        case (s_data.char_code)
                            tcb_pkg::CH_LF: begin
                                cur_col_next = '0;
                                if (row_inc < eff_rows) begin
                                    cur_row_next = RW'(row_inc);
                                end else begin
                                    pend_put_next = 1'b0;
                                    sc_row_next   = '0;
                                    sc_col_next   = '0;
                                    state_next    = sweep_ok ? ST_SWEEP : ST_EVENT;
                                end
                            end
                            tcb_pkg::CH_CR: begin
                                cur_col_next = '0;
                            end
                            tcb_pkg::CH_TAB: begin
                                tab_stop_next = ((CW+1)'(cur_col_reg)
                                                 & ~(CW+1)'(tcb_pkg::TAB_WIDTH - 1))
                                                + (CW+1)'(tcb_pkg::TAB_WIDTH);
                                if (cur_col_reg < eff_cols) begin
                                    state_next = ST_TAB;
                                end
                            end
                            default: begin
                                if (s_data.char_code >= tcb_pkg::CH_SPACE &&
                                    s_data.char_code <= tcb_pkg::CH_TILDE) begin
                                    if (cur_col_reg >= eff_cols) begin
                                        cur_col_next = '0;
                                        if (row_inc < eff_rows) begin
                                            cur_row_next = RW'(row_inc);
                                            state_next   = ST_PUT;
                                        end else begin
                                            pend_put_next = 1'b1;
                                            sc_row_next   = '0;
                                            sc_col_next   = '0;
                                            state_next    = sweep_ok ? ST_SWEEP : ST_EVENT;
                                        end
                                    end else begin
                                        state_next = ST_PUT;
                                    end
                                end
                            end
                        endcase
                    end
                end
            end

            ST_READ: begin
                if (out_free) begin
                    m_valid_next     = 1'b1;
                    m_data_next.kind = tcb_pkg::KIND_READ;
                    m_data_next.row  = req_reg.read_row;
                    m_data_next.col  = req_reg.read_col;
                    m_data_next.code = rd_ok_reg ? rd_data : tcb_pkg::CH_EMPTY;
                    m_data_next.last = 1'b1;
                    state_next       = ST_IDLE;
                end
            end

            ST_TAB: begin
                if (out_free) begin
                    wr_valid_next    = 1'b1;
                    wr_addr_next     = cell_addr(cur_row_reg, cur_col_reg);
                    wr_data_next     = tcb_pkg::CH_SPACE;
                    m_valid_next     = 1'b1;
                    m_data_next.kind = tcb_pkg::KIND_WRITE;
                    m_data_next.row  = 6'(cur_row_reg);
                    m_data_next.col  = 7'(cur_col_reg);
                    m_data_next.code = tcb_pkg::CH_SPACE;
                    m_data_next.last = tab_last;
                    cur_col_next     = CW'(col_inc);
                    if (tab_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_PUT: begin
                if (out_free) begin
                    wr_valid_next    = 1'b1;
                    wr_addr_next     = cell_addr(cur_row_reg, cur_col_reg);
                    wr_data_next     = req_reg.char_code;
                    m_valid_next     = 1'b1;
                    m_data_next.kind = tcb_pkg::KIND_WRITE;
                    m_data_next.row  = 6'(cur_row_reg);
                    m_data_next.col  = 7'(cur_col_reg);
                    m_data_next.code = req_reg.char_code;
                    m_data_next.last = 1'b1;
                    cur_col_next     = CW'(col_inc);
                    state_next       = ST_IDLE;
                end
            end

            ST_SWEEP: begin
                // upper part copies from keep rows below, the rest is cleared
                wr_valid_next = 1'b1;
                wr_addr_next  = cell_addr(sc_row_reg, sc_col_reg);
                wr_data_next  = tcb_pkg::CH_EMPTY;
                if (RW1'(sc_row_reg) < top_rows) begin
                    rd_en           = 1'b1;
                    rd_addr         = cell_addr(RW'(RW1'(sc_row_reg) + keep), sc_col_reg);
                    wr_from_rd_next = 1'b1;
                end
                if ((CW+1)'(sc_col_reg) + (CW+1)'(1) == (CW+1)'(eff_cols)) begin
                    sc_col_next = '0;
                    if (RW1'(sc_row_reg) + RW1'(1) == eff_rows) begin
                        state_next = ST_EVENT;
                    end else begin
                        sc_row_next = sc_row_reg + RW'(1);
                    end
                end else begin
                    sc_col_next = sc_col_reg + CW'(1);
                end
            end

            ST_EVENT: begin
                if (out_free) begin
                    m_valid_next     = 1'b1;
                    m_data_next.kind = tcb_pkg::KIND_SCROLL;
                    m_data_next.row  = 6'(scroll_row);
                    m_data_next.col  = '0;
                    m_data_next.code = tcb_pkg::CH_EMPTY;
                    m_data_next.last = !pend_put_reg;
                    cur_row_next     = scroll_row;
                    cur_col_next     = '0;
                    state_next       = pend_put_reg ? ST_PUT : ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            cur_row_reg  <= '0;
            cur_col_reg  <= '0;
            rows_cfg_reg <= tcb_pkg::ROWS_RESET;
            cols_cfg_reg <= tcb_pkg::COLS_RESET;
            quiet_reg    <= tcb_pkg::QUIET_RESET;
            pend_put_reg <= 1'b0;
            clr_addr_reg <= '0;
            m_valid_reg  <= 1'b0;
            wr_valid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cur_row_reg  <= cur_row_next;
            cur_col_reg  <= cur_col_next;
            rows_cfg_reg <= rows_cfg_next;
            cols_cfg_reg <= cols_cfg_next;
            quiet_reg    <= quiet_next;
            pend_put_reg <= pend_put_next;
            clr_addr_reg <= clr_addr_next;
            m_valid_reg  <= m_valid_next;
            wr_valid_reg <= wr_valid_next;
        end
        req_reg        <= req_next;
        rd_ok_reg      <= rd_ok_next;
        tab_stop_reg   <= tab_stop_next;
        sc_row_reg     <= sc_row_next;
        sc_col_reg     <= sc_col_next;
        m_data_reg     <= m_data_next;
        wr_addr_reg    <= wr_addr_next;
        wr_from_rd_reg <= wr_from_rd_next;
        wr_data_reg    <= wr_data_next;
    end

endmodule

// ----- dv/text_console_buffer_top_test.sv -----
// ----------------------------------------------------------------------------
// text_console_buffer_top_test
// Self-checking bench for the text console character buffer. A table of
// directed puts and reads runs first, then random traffic over a series of
// row, column and quiet settings, from the smallest to beyond the store size.
// Every result transfer is checked in order against a console shadow that
// tracks the cursor, wrap, tab, scroll and the stored characters.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module text_console_buffer_top_test;

    localparam int MAX_ROWS      = 64;
    localparam int MAX_COLS      = 96;
    localparam int SETTLE_CYCLES = 128 * 128 + 64;
    localparam int HOLD_CYCLES   = 300;

    typedef enum logic [1:0] {
        BY_PREDICTOR,
        NOTHING_BACK,
        EMPTY_CELL,
        AT_HOME
    } row_check_t;

    typedef struct packed {
        tcb_pkg::tcb_in_t item;
        row_check_t       check;
    } stim_row_t;

    logic                           aclk      = 1'b0;
    logic                           aresetn   = 1'b0;
    logic                           s_valid   = 1'b0;
    logic                           s_ready;
    tcb_pkg::tcb_in_t               s_data    = '0;
    logic                           m_valid;
    logic                           m_ready   = 1'b0;
    tcb_pkg::tcb_out_t              m_data;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [tcb_pkg::CFG_IDX_W-1:0]  cfg_index = tcb_pkg::REG_ROWS;
    logic [tcb_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    // console shadow
    logic [7:0]        shadow_text [MAX_ROWS][MAX_COLS];
    int                cur_row;
    int                cur_col;
    int                rows_reg;
    int                cols_reg;
    logic              quiet_reg;
    tcb_pkg::tcb_out_t cells_due [$];

    int items_sent       = 0;
    int results_seen     = 0;
    int scrolls_seen     = 0;
    int fail_count       = 0;
    int settings_applied = 0;

    int tx_idle_pct   = 0;
    int rx_stall_pct  = 0;
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;

    text_console_buffer_top #(
        .MAX_ROWS(MAX_ROWS),
        .MAX_COLS(MAX_COLS)
    ) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic int used_rows();
        return (rows_reg > MAX_ROWS) ? MAX_ROWS : rows_reg;
    endfunction

    function automatic int used_cols();
        return (cols_reg > MAX_COLS) ? MAX_COLS : cols_reg;
    endfunction

    function automatic void note_cell(logic [1:0] kind, int row, int col, logic [7:0] code);
        tcb_pkg::tcb_out_t res;
        res.kind = kind;
        res.row  = row[5:0];
        res.col  = col[6:0];
        res.code = code;
        res.last = 1'b0;
        cells_due.push_back(res);
    endfunction

    // returns 1 when the screen scrolled
    function automatic bit advance_line();
        int nrows;
        int ncols;
        int keep;
        int r;
        int c;
        nrows   = used_rows();
        ncols   = used_cols();
        cur_col = 0;
        cur_row++;
        if (cur_row < nrows) begin
            return 1'b0;
        end
        keep = nrows / 2;
        for (r = 0; r < nrows; r++) begin
            for (c = 0; c < ncols; c++) begin
                shadow_text[r][c] = (r + keep < nrows) ? shadow_text[r + keep][c]
                                                       : tcb_pkg::CH_EMPTY;
            end
        end
        cur_row = nrows - keep;
        if (cur_row >= MAX_ROWS) begin
            cur_row = MAX_ROWS - 1;
        end
        return 1'b1;
    endfunction

    function automatic void console_apply(tcb_pkg::tcb_in_t it);
        int                first;
        int                stop;
        logic [7:0]        code;
        tcb_pkg::tcb_out_t res;
        first = cells_due.size();
        if (it.func == tcb_pkg::FUNC_READ) begin
            code = tcb_pkg::CH_EMPTY;
            if (it.read_col < MAX_COLS) begin
                code = shadow_text[it.read_row][it.read_col];
            end
            note_cell(tcb_pkg::KIND_READ, int'(it.read_row), int'(it.read_col), code);
        end else if (quiet_reg && !it.force_req) begin
            // dropped
        end else if (it.char_code == tcb_pkg::CH_LF) begin
            if (advance_line()) begin
                note_cell(tcb_pkg::KIND_SCROLL, cur_row, 0, tcb_pkg::CH_EMPTY);
            end
        end else if (it.char_code == tcb_pkg::CH_CR) begin
            cur_col = 0;
        end else if (it.char_code == tcb_pkg::CH_TAB) begin
            stop = (cur_col / tcb_pkg::TAB_WIDTH + 1) * tcb_pkg::TAB_WIDTH;
            while (cur_col < stop && cur_col < used_cols()) begin
                shadow_text[cur_row][cur_col] = tcb_pkg::CH_SPACE;
                note_cell(tcb_pkg::KIND_WRITE, cur_row, cur_col, tcb_pkg::CH_SPACE);
                cur_col++;
            end
        end else if (it.char_code >= tcb_pkg::CH_SPACE &&
                     it.char_code <= tcb_pkg::CH_TILDE) begin
            if (cur_col >= used_cols()) begin
                if (advance_line()) begin
                    note_cell(tcb_pkg::KIND_SCROLL, cur_row, 0, tcb_pkg::CH_EMPTY);
                end
            end
            if (cur_col < MAX_COLS) begin
                shadow_text[cur_row][cur_col] = it.char_code;
                note_cell(tcb_pkg::KIND_WRITE, cur_row, cur_col, it.char_code);
                cur_col++;
            end
        end
        if (cells_due.size() > first) begin
            res      = cells_due.pop_back();
            res.last = 1'b1;
            cells_due.push_back(res);
        end
    endfunction

    function automatic stim_row_t mk_row(logic func, logic [7:0] ch, logic frc,
                                         logic [5:0] rr, logic [6:0] rc, row_check_t check);
        stim_row_t row;
        row.item.func      = func;
        row.item.char_code = ch;
        row.item.force_req = frc;
        row.item.read_row  = rr;
        row.item.read_col  = rc;
        row.check          = check;
        return row;
    endfunction

    function automatic tcb_pkg::tcb_in_t random_item();
        tcb_pkg::tcb_in_t it;
        int               pick;
        it.func = ($urandom_range(99) < 20) ? tcb_pkg::FUNC_READ : tcb_pkg::FUNC_PUT;
        pick = $urandom_range(99);
        if (pick < 55) begin
            it.char_code = 8'($urandom_range(tcb_pkg::CH_TILDE, tcb_pkg::CH_SPACE));
        end else if (pick < 67) begin
            it.char_code = tcb_pkg::CH_LF;
        end else if (pick < 75) begin
            it.char_code = tcb_pkg::CH_CR;
        end else if (pick < 85) begin
            it.char_code = tcb_pkg::CH_TAB;
        end else begin
            it.char_code = 8'($urandom_range(255));
        end
        it.force_req = 1'($urandom_range(1));
        if ($urandom_range(99) < 70 && used_rows() > 0) begin
            it.read_row = 6'($urandom_range(used_rows() - 1));
        end else begin
            it.read_row = 6'($urandom_range(63));
        end
        if ($urandom_range(99) < 70 && used_cols() > 0) begin
            it.read_col = 7'($urandom_range(used_cols() - 1));
        end else begin
            it.read_col = 7'($urandom_range(127));
        end
        return it;
    endfunction

    task automatic send_item(tcb_pkg::tcb_in_t it, row_check_t check);
        int                first;
        tcb_pkg::tcb_out_t res;
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!(s_valid && s_ready)) begin
            @(posedge aclk);
        end
        first = cells_due.size();
        console_apply(it);
        if (check != BY_PREDICTOR) begin
            while (cells_due.size() > first) begin
                res = cells_due.pop_back();
            end
            res.last = 1'b1;
            if (check == EMPTY_CELL) begin
                res.kind = tcb_pkg::KIND_READ;
                res.row  = it.read_row;
                res.col  = it.read_col;
                res.code = tcb_pkg::CH_EMPTY;
                cells_due.push_back(res);
            end else if (check == AT_HOME) begin
                res.kind = tcb_pkg::KIND_WRITE;
                res.row  = '0;
                res.col  = '0;
                res.code = it.char_code;
                cells_due.push_back(res);
            end
        end
        items_sent++;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (cells_due.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic apply_setup(int rows, int cols, logic quiet);
        logic [tcb_pkg::CFG_IDX_W-1:0]  idx [3];
        logic [tcb_pkg::CFG_DATA_W-1:0] val [3];
        int                             i;
        idx[0] = tcb_pkg::REG_ROWS;
        idx[1] = tcb_pkg::REG_COLS;
        idx[2] = tcb_pkg::REG_QUIET;
        val[0] = rows[6:0];
        val[1] = cols[6:0];
        val[2] = 7'($urandom_range(127));
        val[2][0] = quiet;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        for (i = 0; i < 3; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            @(posedge aclk);
            while (!(cfg_valid && cfg_ready)) begin
                @(posedge aclk);
            end
            case (idx[i])
                tcb_pkg::REG_ROWS: begin
                    rows_reg = int'(val[i]);
                end
                tcb_pkg::REG_COLS: begin
                    cols_reg = int'(val[i]);
                end
                tcb_pkg::REG_QUIET: begin
                    quiet_reg = val[i][0];
                end
                default: begin
                end
            endcase
        end
        cfg_valid <= 1'b0;
        settings_applied++;
    endtask

    task automatic run_phase(int rows, int cols, logic quiet, int tx_pct, int rx_pct, int count);
        apply_setup(rows, cols, quiet);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        repeat (count) send_item(random_item(), BY_PREDICTOR);
    endtask

    // result side: random stalls plus long hold-offs on request
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_served != hold_requests) begin
            m_ready     <= 1'b0;
            hold_left   <= HOLD_CYCLES;
            hold_served <= hold_requests;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge aclk) begin : result_check
        tcb_pkg::tcb_out_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (m_data.kind == tcb_pkg::KIND_SCROLL) begin
                scrolls_seen++;
            end
            if (cells_due.size() == 0) begin
                fail_count++;
                if (fail_count <= 10) begin
                    $display("%0t: unexpected transfer: kind %0d row %0d col %0d code %h last %0d",
                             $realtime, m_data.kind, m_data.row, m_data.col, m_data.code,
                             m_data.last);
                end
            end else begin
                want = cells_due.pop_front();
                if (m_data.kind !== want.kind || m_data.row !== want.row ||
                    m_data.col !== want.col || m_data.code !== want.code ||
                    m_data.last !== want.last) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("%0t: mismatch: expected kind %0d row %0d col %0d code %h last %0d",
                                 $realtime, want.kind, want.row, want.col, want.code, want.last);
                        $display("%0t:           got kind %0d row %0d col %0d code %h last %0d",
                                 $realtime, m_data.kind, m_data.row, m_data.col, m_data.code,
                                 m_data.last);
                    end
                end
            end
        end
    end

    initial begin : stimulus
        stim_row_t directed_rows [$];
        int        i;
        int        r;
        int        c;

        directed_rows.push_back(mk_row(tcb_pkg::FUNC_READ, 8'h00, 1'b0, 6'd0, 7'd0, EMPTY_CELL));
        directed_rows.push_back(mk_row(tcb_pkg::FUNC_READ, 8'h00, 1'b0, 6'd63, 7'd127,
                                       EMPTY_CELL));
        directed_rows.push_back(mk_row(tcb_pkg::FUNC_READ, 8'h00, 1'b0, 6'd0, 7'd95, EMPTY_CELL));
        directed_rows.push_back(mk_row(tcb_pkg::FUNC_READ, 8'h00, 1'b0, 6'd5, 7'd96, EMPTY_CELL));
        directed_rows.push_back(mk_row(tcb_pkg::FUNC_PUT, "A", 1'b0, 6'd0, 7'd0, NOTHING_BACK));
        directed_rows.push_back(mk_row(tcb_pkg::FUNC_PUT, "A", 1'b1, 6'd0, 7'd0, AT_HOME));
        directed_rows.push_back(mk_row(tcb_pkg::FUNC_PUT, tcb_pkg::CH_SPACE, 1'b1, 6'd0, 7'd0,
                                       BY_PREDICTOR));
        directed_rows.push_back(mk_row(tcb_pkg::FUNC_PUT, tcb_pkg::CH_TILDE, 1'b1, 6'd0, 7'd0,
                                       BY_PREDICTOR));
        directed_rows.push_back(mk_row(tcb_pkg::FUNC_PUT, 8'h1F, 1'b1, 6'd0, 7'd0, BY_PREDICTOR));
        directed_rows.push_back(mk_row(tcb_pkg::FUNC_PUT, 8'h7F, 1'b1, 6'd0, 7'd0, BY_PREDICTOR));
        directed_rows.push_back(mk_row(tcb_pkg::FUNC_PUT, 8'h00, 1'b1, 6'd0, 7'd0, BY_PREDICTOR));
        directed_rows.push_back(mk_row(tcb_pkg::FUNC_PUT, 8'hFF, 1'b1, 6'd0, 7'd0, BY_PREDICTOR));
        directed_rows.push_back(mk_row(tcb_pkg::FUNC_PUT, tcb_pkg::CH_TAB, 1'b1, 6'd0, 7'd0,
                                       BY_PREDICTOR));
        directed_rows.push_back(mk_row(tcb_pkg::FUNC_PUT, tcb_pkg::CH_TAB, 1'b1, 6'd0, 7'd0,
                                       BY_PREDICTOR));
        directed_rows.push_back(mk_row(tcb_pkg::FUNC_PUT, tcb_pkg::CH_CR, 1'b1, 6'd0, 7'd0,
                                       BY_PREDICTOR));
        directed_rows.push_back(mk_row(tcb_pkg::FUNC_PUT, tcb_pkg::CH_TAB, 1'b1, 6'd0, 7'd0,
                                       BY_PREDICTOR));
        directed_rows.push_back(mk_row(tcb_pkg::FUNC_PUT, tcb_pkg::CH_LF, 1'b1, 6'd0, 7'd0,
                                       BY_PREDICTOR));
        directed_rows.push_back(mk_row(tcb_pkg::FUNC_READ, 8'h00, 1'b0, 6'd0, 7'd0,
                                       BY_PREDICTOR));
        directed_rows.push_back(mk_row(tcb_pkg::FUNC_READ, 8'h00, 1'b0, 6'd0, 7'd2,
                                       BY_PREDICTOR));
        directed_rows.push_back(mk_row(tcb_pkg::FUNC_READ, 8'h00, 1'b0, 6'd0, 7'd7,
                                       BY_PREDICTOR));
        directed_rows.push_back(mk_row(tcb_pkg::FUNC_PUT, tcb_pkg::CH_LF, 1'b0, 6'd0, 7'd0,
                                       BY_PREDICTOR));
        directed_rows.push_back(mk_row(tcb_pkg::FUNC_PUT, "z", 1'b1, 6'd0, 7'd0, BY_PREDICTOR));
        directed_rows.push_back(mk_row(tcb_pkg::FUNC_READ, 8'h00, 1'b0, 6'd1, 7'd0,
                                       BY_PREDICTOR));
        directed_rows.push_back(mk_row(tcb_pkg::FUNC_READ, 8'h00, 1'b1, 6'd63, 7'd0,
                                       BY_PREDICTOR));

        for (r = 0; r < MAX_ROWS; r++) begin
            for (c = 0; c < MAX_COLS; c++) begin
                shadow_text[r][c] = tcb_pkg::CH_EMPTY;
            end
        end
        cur_row   = 0;
        cur_col   = 0;
        rows_reg  = int'(tcb_pkg::ROWS_RESET);
        cols_reg  = int'(tcb_pkg::COLS_RESET);
        quiet_reg = tcb_pkg::QUIET_RESET;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (i = 0; i < directed_rows.size(); i++) begin
            send_item(directed_rows[i].item, directed_rows[i].check);
        end

        run_phase(2, 8, 1'b0, 0, 0, 40);
        run_phase(64, 96, 1'b0, 0, 84, 20);
        run_phase(127, 127, 1'b1, 17, 17, 12);
        run_phase(5, 3, 1'b1, 84, 0, 35);
        run_phase(1, 4, 1'b0, 17, 17, 12);
        run_phase(0, 0, 1'b0, 0, 0, 10);

        // fill the block while the result side holds off, then let it drain
        run_phase(3, 6, 1'b0, 0, 0, 0);
        hold_requests <= hold_requests + 1;
        repeat (25) send_item(random_item(), BY_PREDICTOR);
        wait_drained();
        tx_idle_pct  = 17;
        rx_stall_pct = 17;
        repeat (20) send_item(random_item(), BY_PREDICTOR);

        run_phase(28, 33, 1'b1, 0, 84, 30);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("run covered %0d items (%0d from the table), %0d results, %0d scrolls",
                 items_sent, directed_rows.size(), results_seen, scrolls_seen);
        $display("%0d register settings, row and column counts from 0 to 127, quiet on and off",
                 settings_applied);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #(64'd40_000_000);
        $display("timeout with %0d results still pending", cells_due.size());
        $display("Verification failed");
        $finish;
    end

endmodule
